[src/adam_pkg.sv]
// ----------------------------------------------------------------------------
// adam_pkg
// Shared types, constants and register codes for the Adam update block.
// ----------------------------------------------------------------------------
package adam_pkg;

    localparam int INDEX_W     = 8;
    localparam int PARAM_COUNT = 1 << INDEX_W;
    localparam int CFG_IDX_W   = 3;
    localparam int ACC_W       = 100;
    localparam int MUL_W       = 34;

    // configuration register codes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATIENCE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_TERM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BEST     = 3'd6;

    // reset values
    localparam logic [31:0]        RST_RATE     = 32'd4294967;
    localparam logic [30:0]        RST_MARGIN   = 31'd66;
    localparam logic [15:0]        RST_PATIENCE = 16'd10;
    localparam logic [15:0]        RST_BETA1    = 16'd58982;
    localparam logic [15:0]        RST_BETA2    = 16'd65470;
    localparam logic [31:0]        RST_EPSILON  = 32'd43;
    localparam logic signed [31:0] RST_BEST     = 32'sh7FFF_FFFF;
    localparam logic [32:0]        ONE_Q32      = 33'h1_0000_0000;
    // ceil(2^35 / 10): floor(x * MARGIN_RECIP / 2^35) is floor(x / 10) for 32-bit x
    localparam logic [MUL_W-1:0]   MARGIN_RECIP = 34'h0_CCCC_CCCD;
    localparam logic [33:0]        STEP_CLAMP   = 34'h2_0000_0000;

    typedef struct packed {
        logic [INDEX_W-1:0] param_index;
        logic signed [31:0] param_value;
        logic signed [31:0] gradient;
        logic               frozen;
        logic               step_start;
        logic signed [31:0] objective;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic               plateau_seen;
        logic [31:0]        current_rate;
        logic [31:0]        step_number;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [6:0]  shift;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PWR1,
        ST_PWR2,
        ST_PLAT,
        ST_MARGIN,
        ST_M1,
        ST_M2,
        ST_G2,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_V4,
        ST_V5,
        ST_MHAT,
        ST_VQ,
        ST_SQRT,
        ST_RATIO,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_DONE
    } adam_state_t;

endpackage

[src/adam_update_with_plateau_decay.sv]
// ----------------------------------------------------------------------------
// adam_update_with_plateau_decay
// Fixed-point Adam parameter update with plateau-driven learning-rate decay.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per parameter item (index, value, gradient, frozen,
//           step_start, objective). step_start opens a new optimization step.
//   out_* : one transaction per item: new value, plateau flag, rate, step count.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Sequencing:
//   One item at a time; in_ready is high only in idle. A frozen item without
//   step start goes straight to the done state. A step start adds the power
//   updates and the plateau test, plus a margin state when a plateau divides
//   the margin by ten (reciprocal multiply). An unfrozen item adds the moment
//   and rate multiplies and three divisions and a root on the shared iterative
//   units; the divider makes one quotient bit per cycle.
// Reset: moments read as zero (per-entry valid bits), powers are one, step
//   count and patience zero, rate/margin/best take their reset values.
// Stall: a finished result waits in the output register; the next item is
//   still taken and computed, then holds in its last state until it frees.
// ----------------------------------------------------------------------------
module adam_update_with_plateau_decay
    import adam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    adam_state_t state_reg, state_next;

    // configuration and step state
    logic [15:0]        plim_reg;
    logic [15:0]        b1_reg;
    logic [15:0]        b2_reg;
    logic [31:0]        eps_reg;
    logic [31:0]        rate_reg;
    logic [30:0]        margin_reg;
    logic signed [31:0] best_reg;
    logic [15:0]        pat_reg;
    logic [32:0]        pf_reg;
    logic [32:0]        ps_reg;
    logic [31:0]        step_cnt_reg;
    logic               plat_reg;

    // moment stores
    logic signed [31:0] fm_mem [PARAM_COUNT];
    logic [47:0]        sm_mem [PARAM_COUNT];
    logic [PARAM_COUNT-1:0] vld_reg;
    logic signed [31:0] fm_rd_reg;
    logic [47:0]        sm_rd_reg;
    logic               vld_rd_reg;

    // item and working registers
    in_item_t           item_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0] m_reg;
    logic [47:0]        gsq_reg;
    logic [47:0]        v_reg;
    logic [63:0]        mhat_reg;
    logic [63:0]        ratio_reg;
    logic signed [31:0] result_reg;

    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    // derived values
    logic               in_fire;
    logic               cfg_fire;
    logic signed [31:0] m_old;
    logic [47:0]        v_old;
    logic [31:0]        g_abs;
    logic [31:0]        m_abs;
    logic [16:0]        c1, c2;
    logic [32:0]        d1_raw, d2_raw, d1, d2;
    logic signed [33:0] plat_lhs, plat_rhs;
    logic               better;
    logic [15:0]        pat_inc;
    logic               plateau;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] prod_hi;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sum_hi;
    logic [47:0]        step_raw;
    logic [33:0]        step_sat;
    logic signed [35:0] upd;
    logic signed [31:0] upd_sat;
    logic               out_free;

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign out_free  = !out_valid_reg || out_ready;

    assign m_old = vld_rd_reg ? fm_rd_reg : 32'sd0;
    assign v_old = vld_rd_reg ? sm_rd_reg : 48'd0;
    assign g_abs = item_reg.gradient[31] ? 32'(-item_reg.gradient) : item_reg.gradient;
    assign m_abs = m_reg[31] ? 32'(-m_reg) : m_reg;
    assign c1    = 17'h1_0000 - {1'b0, b1_reg};
    assign c2    = 17'h1_0000 - {1'b0, b2_reg};

    // bias-correction denominators; zero means no correction yet
    assign d1_raw = ONE_Q32 - pf_reg;
    assign d2_raw = ONE_Q32 - ps_reg;
    assign d1     = (d1_raw == '0) ? ONE_Q32 : d1_raw;
    assign d2     = (d2_raw == '0) ? ONE_Q32 : d2_raw;

    // plateau test
    assign plat_lhs = 34'(item_reg.objective);
    assign plat_rhs = 34'(best_reg) - $signed({3'b000, margin_reg});
    assign better   = plat_lhs < plat_rhs;
    assign pat_inc  = pat_reg + 16'd1;
    assign plateau  = !better && (pat_inc >= plim_reg);

    // accumulate paths
    assign prod_ext   = ACC_W'(prod);
    assign prod_hi    = prod_ext <<< 32;
    assign acc_sum    = acc_reg + prod_ext;
    assign acc_sum_hi = acc_reg + prod_hi;

    // final step and update
    assign step_raw = acc_sum_hi[95:48];
    assign step_sat = (step_raw > 48'(STEP_CLAMP)) ? STEP_CLAMP : step_raw[33:0];
    assign upd      = m_reg[31] ? 36'(item_reg.param_value) + $signed({2'b00, step_sat})
                                : 36'(item_reg.param_value) - $signed({2'b00, step_sat});
    always_comb
    begin
        if (upd > 36'sh0_7FFF_FFFF)
            upd_sat = 32'sh7FFF_FFFF;
        else if (upd < -36'sh0_8000_0000)
            upd_sat = 32'sh8000_0000;
        else
            upd_sat = upd[31:0];
    end

    adam_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    adam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    adam_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.step_start)
                        state_next = ST_PWR1;
                    else if (in_data.frozen)
                        state_next = ST_DONE;
                    else
                        state_next = ST_M1;
                end
            end
            ST_PWR1:  state_next = ST_PWR2;
            ST_PWR2:  state_next = ST_PLAT;
            ST_PLAT:
            begin
                if (plateau)
                    state_next = ST_MARGIN;
                else if (item_reg.frozen)
                    state_next = ST_DONE;
                else
                    state_next = ST_M1;
            end
            ST_MARGIN:
            begin
                state_next = item_reg.frozen ? ST_DONE : ST_M1;
            end
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_G2;
            ST_G2:    state_next = ST_V1;
            ST_V1:    state_next = ST_V2;
            ST_V2:    state_next = ST_V3;
            ST_V3:    state_next = ST_V4;
            ST_V4:    state_next = ST_V5;
            ST_V5:    state_next = ST_MHAT;
            ST_MHAT:  if (div_rsp.done)  state_next = ST_VQ;
            ST_VQ:    if (div_rsp.done)  state_next = ST_SQRT;
            ST_SQRT:  if (sqrt_rsp.done) state_next = ST_RATIO;
            ST_RATIO: if (div_rsp.done)  state_next = ST_R1;
            ST_R1:    state_next = ST_R2;
            ST_R2:    state_next = ST_R3;
            ST_R3:    state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_ready       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        sqrt_req       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_PWR1:
            begin
                mul_a = MUL_W'(pf_reg);
                mul_b = MUL_W'(b1_reg);
            end
            ST_PWR2:
            begin
                mul_a = MUL_W'(ps_reg);
                mul_b = MUL_W'(b2_reg);
            end
            ST_PLAT:
            begin
                // margin / 10 by reciprocal, used only on a plateau
                mul_a = MUL_W'(margin_reg);
                mul_b = MARGIN_RECIP;
            end
            ST_M1:
            begin
                mul_a = MUL_W'(m_old);
                mul_b = MUL_W'(b1_reg);
            end
            ST_M2:
            begin
                mul_a = MUL_W'(item_reg.gradient);
                mul_b = MUL_W'(c1);
            end
            ST_G2:
            begin
                mul_a = MUL_W'(g_abs);
                mul_b = MUL_W'(g_abs);
            end
            ST_V1:
            begin
                mul_a = MUL_W'(v_old[31:0]);
                mul_b = MUL_W'(b2_reg);
            end
            ST_V2:
            begin
                mul_a = MUL_W'(v_old[47:32]);
                mul_b = MUL_W'(b2_reg);
            end
            ST_V3:
            begin
                mul_a = MUL_W'(gsq_reg[31:0]);
                mul_b = MUL_W'(c2);
            end
            ST_V4:
            begin
                mul_a = MUL_W'(gsq_reg[47:32]);
                mul_b = MUL_W'(c2);
            end
            ST_V5:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'(m_abs);
                div_req.den   = 64'(d1);
                div_req.shift = 7'd32;
            end
            ST_MHAT:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = 64'(v_reg);
                div_req.den   = 64'(d2);
                div_req.shift = 7'd48;
            end
            ST_VQ:
            begin
                sqrt_req.start = div_rsp.done;
                sqrt_req.x     = div_rsp.quo;
            end
            ST_SQRT:
            begin
                div_req.start = sqrt_rsp.done;
                div_req.num   = mhat_reg;
                div_req.den   = {16'd0, sqrt_rsp.root, 16'd0} + 64'(eps_reg);
                div_req.shift = 7'd48;
            end
            ST_R1:
            begin
                mul_a = MUL_W'(rate_reg);
                mul_b = MUL_W'(ratio_reg[31:0]);
            end
            ST_R2:
            begin
                mul_a = MUL_W'(rate_reg);
                mul_b = MUL_W'(ratio_reg[63:32]);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------- control and step state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plim_reg      <= RST_PATIENCE;
            b1_reg        <= RST_BETA1;
            b2_reg        <= RST_BETA2;
            eps_reg       <= RST_EPSILON;
            rate_reg      <= RST_RATE;
            margin_reg    <= RST_MARGIN;
            best_reg      <= RST_BEST;
            pat_reg       <= '0;
            pf_reg        <= ONE_Q32;
            ps_reg        <= ONE_Q32;
            step_cnt_reg  <= '0;
            plat_reg      <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_RATE:   rate_reg   <= cfg_data;
                    CFG_INITIAL_MARGIN: margin_reg <= cfg_data[30:0];
                    CFG_PATIENCE_LIMIT: plim_reg   <= cfg_data[15:0];
                    CFG_BETA_FIRST:     b1_reg     <= cfg_data[15:0];
                    CFG_BETA_SECOND:    b2_reg     <= cfg_data[15:0];
                    CFG_EPSILON_TERM:   eps_reg    <= cfg_data;
                    CFG_START_BEST:     best_reg   <= cfg_data;
                    default:            plim_reg   <= plim_reg;
                endcase
            end

            if (in_fire)
                plat_reg <= 1'b0;

            if (state_reg == ST_PWR1)
                step_cnt_reg <= step_cnt_reg + 32'd1;
            if (state_reg == ST_PWR2)
                pf_reg <= prod[48:16];
            if (state_reg == ST_PLAT)
            begin
                ps_reg <= prod[48:16];
                if (better)
                begin
                    best_reg <= item_reg.objective;
                    pat_reg  <= '0;
                end
                else if (plateau)
                begin
                    pat_reg  <= '0;
                    plat_reg <= 1'b1;
                    rate_reg <= rate_reg >> 1;
                end
                else
                begin
                    pat_reg <= pat_inc;
                end
            end
            if (state_reg == ST_MARGIN)
                margin_reg <= prod[65:35];

            if (state_reg == ST_V5)
                vld_reg[item_reg.param_index] <= 1'b1;

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath and moment stores ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg   <= in_data;
            fm_rd_reg  <= fm_mem[in_data.param_index];
            sm_rd_reg  <= sm_mem[in_data.param_index];
            vld_rd_reg <= vld_reg[in_data.param_index];
            result_reg <= in_data.param_value;
        end

        unique case (state_reg)
            ST_M2:   acc_reg <= prod_ext;
            ST_G2:   m_reg   <= acc_sum[47:16];
            ST_V1:   gsq_reg <= prod[63:16];
            ST_V2:   acc_reg <= prod_ext;
            ST_V3:   acc_reg <= acc_sum_hi;
            ST_V4:   acc_reg <= acc_sum;
            ST_V5:
            begin
                v_reg <= acc_sum_hi[63:16];
                fm_mem[item_reg.param_index] <= m_reg;
                sm_mem[item_reg.param_index] <= acc_sum_hi[63:16];
            end
            ST_MHAT: if (div_rsp.done) mhat_reg <= div_rsp.quo;
            ST_RATIO: if (div_rsp.done) ratio_reg <= div_rsp.quo;
            ST_R2:   acc_reg <= prod_ext;
            ST_R3:   result_reg <= upd_sat;
            default: acc_reg <= acc_reg;
        endcase

        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.new_value    <= result_reg;
            out_data_reg.plateau_seen <= plat_reg;
            out_data_reg.current_rate <= rate_reg;
            out_data_reg.step_number  <= step_cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/adam_mul.sv]
// ----------------------------------------------------------------------------
// adam_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module adam_mul
    import adam_pkg::*;
(
    input  logic                          clk,
    input  logic signed [MUL_W-1:0]       a,
    input  logic signed [MUL_W-1:0]       b,
    output logic signed [2*MUL_W-1:0]     prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[src/adam_div.sv]
// ----------------------------------------------------------------------------
// adam_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^shift / den),
// saturated to 64 bits.
// ----------------------------------------------------------------------------
module adam_div
    import adam_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic        sat_reg;
    logic        den_zero_reg;
    logic        num_zero_reg;

    logic [64:0] trial;
    logic        ge;
    logic [64:0] diff;

    assign trial = {rem_reg, num_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd64 + req.shift;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg      <= req.num;
            den_reg      <= req.den;
            rem_reg      <= '0;
            quo_reg      <= '0;
            sat_reg      <= 1'b0;
            den_zero_reg <= (req.den == '0);
            num_zero_reg <= (req.num == '0);
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            sat_reg <= sat_reg | quo_reg[63];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (den_zero_reg)
            rsp.quo = num_zero_reg ? '0 : '1;
        else
            rsp.quo = sat_reg ? '1 : quo_reg;
    end

endmodule

[src/adam_sqrt.sv]
// ----------------------------------------------------------------------------
// adam_sqrt
// Digit-by-digit integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module adam_sqrt
    import adam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;

    logic [64:0] trial;
    logic        ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, x_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg   <= x_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule
